FILE: src/pwmtone_pkg.sv
// shared types, constants and codes for the pwm tone melody sequencer
`timescale 1ns / 1ps

package pwmtone_pkg;

   localparam int MELODY_DEPTH_DEF   = 16;
   localparam int TIMER_CLOCK_HZ_DEF = 1000000;

   // slide interval in milliseconds and duty scale in percent
   localparam int SLIDE_STEP_MS = 5;
   localparam int PERCENT_SCALE = 100;

   // widest duty * period product: 100 * 65535 needs 23 bits
   localparam int PRODUCT_W = 23;

   // divide by 100 as multiply by ceil(2^30 / 100) and shift by 30,
   // exact for every product below 2^23
   localparam int              RECIP_W       = 24;
   localparam int              RECIP_SHIFT   = 30;
   localparam logic [RECIP_W-1:0] PERCENT_RECIP = 24'd10737419;

   localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
   localparam logic [6:0]  DUTY_MAX   = 7'd100;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_TONE   = 2'd1,
      REQ_WRITE  = 2'd2,
      REQ_MELODY = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_LOAD,
      S_RELOAD,
      S_DIV_PERIOD,
      S_MUL,
      S_SCALE,
      S_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [15:0]       freq;
      logic [6:0]        duty;
      logic signed [7:0] slide;
      logic [15:0]       dur;
   } tone_type;

endpackage

FILE: src/pwmtone_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pwmtone_div #(
   parameter int WIDTH = pwmtone_pkg::PRODUCT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [15:0]      divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [16:0]      shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? 16'(shifted - {1'b0, dsr_ff}) : shifted[15:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/pwmtone_store.sv
// melody entry memory, one write and one registered read port
`timescale 1ns / 1ps

module pwmtone_store #(
   parameter int DEPTH = pwmtone_pkg::MELODY_DEPTH_DEF,
   parameter int AW    = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  pwmtone_pkg::tone_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output pwmtone_pkg::tone_type rd_data
);

   pwmtone_pkg::tone_type mem [DEPTH];
   pwmtone_pkg::tone_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pwm_tone_melody_sequencer_core.sv
// top level of the pwm tone melody sequencer: sequencer, tone state and outputs
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   req_type, tone fields, entry_index, melody_count
// rsp_      out        rsp_valid / rsp_stall   period_top, compare_value, sound_on, tone/melody
// csr_      in         csr_wr_en               csr_wr_data (mute)
//
// states from the accepting edge to rsp_valid: s_finish for start tone, entry write, zero-count
// start; s_load, s_finish for a melody start (registered memory read); s_tick, s_finish for a
// tick that pauses or ends the melody; s_tick, s_load or s_reload, s_finish if it advances the
// melody or finds zero frequency; a reloading tick waits on the bit-serial period divider
// synchronous active-high reset; the melody memory holds garbage until written
// one request in flight; a new request is taken while the last response waits

module pwm_tone_melody_sequencer_core #(
   parameter int MELODY_DEPTH   = pwmtone_pkg::MELODY_DEPTH_DEF,
   parameter int TIMER_CLOCK_HZ = pwmtone_pkg::TIMER_CLOCK_HZ_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [15:0]       req_tone_frequency,
   input  logic [6:0]        req_tone_duty,
   input  logic signed [7:0] req_tone_slide,
   input  logic [15:0]       req_tone_duration,
   input  logic [3:0]        req_entry_index,
   input  logic [4:0]        req_melody_count,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_period_top,
   output logic [15:0]       rsp_compare_value,
   output logic              rsp_sound_on,
   output logic              rsp_tone_active,
   output logic              rsp_melody_active,
   // mute register
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   // memory address width, at least one bit
   localparam int AW = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
   // divider width covers the timer clock and keeps one bit above the 16-bit period
   localparam int HZ_W  = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int DIV_W = (HZ_W > 17) ? HZ_W : 17;
   localparam int SCALED_W = pwmtone_pkg::PRODUCT_W + pwmtone_pkg::RECIP_W;
   localparam logic [DIV_W-1:0] HZ_VALUE = DIV_W'(TIMER_CLOCK_HZ);
   localparam logic [8:0]       DEPTH9   = 9'(MELODY_DEPTH);
   localparam logic [31:0]      SLIDE_MS = 32'(pwmtone_pkg::SLIDE_STEP_MS);

   pwmtone_pkg::seq_state_type state_ff, state_in;

   logic [31:0]       time_now_ff, time_now_in;
   logic [31:0]       tone_begin_ff, tone_begin_in;
   logic [31:0]       slide_mark_ff, slide_mark_in;
   logic [15:0]       tone_length_ff, tone_length_in;
   logic [15:0]       cur_freq_ff, cur_freq_in;
   logic [6:0]        cur_duty_ff, cur_duty_in;
   logic signed [7:0] cur_slide_ff, cur_slide_in;
   logic [15:0]       period_ff, period_in;
   logic [15:0]       pulse_ff, pulse_in;
   logic [4:0]        melody_pos_ff, melody_pos_in;
   logic [4:0]        melody_len_ff, melody_len_in;
   logic              melody_on_ff, melody_on_in;
   logic              paused_ff, paused_in;
   logic              mute_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_period_ff, rsp_period_in;
   logic [15:0]       rsp_compare_ff, rsp_compare_in;
   logic              rsp_sound_ff, rsp_sound_in;
   logic              rsp_tone_ff, rsp_tone_in;
   logic              rsp_melody_ff, rsp_melody_in;

   logic                  accept;
   logic                  rsp_free;
   pwmtone_pkg::req_kind_type kind;
   logic [31:0]           tone_elapsed;
   logic [31:0]           slide_elapsed;
   logic                  tone_running;
   logic signed [17:0]    slide_sum;
   logic [4:0]            pos_next;
   logic [8:0]            pos_next9;
   logic [8:0]            index9;
   logic [8:0]            count9;
   logic [6:0]            duty_eff;
   logic [pwmtone_pkg::PRODUCT_W-1:0] product_ff, product_in;
   logic [SCALED_W-1:0]   scaled;

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [AW-1:0]         mem_rd_addr;
   pwmtone_pkg::tone_type mem_wr_data;
   pwmtone_pkg::tone_type mem_rd_data;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [15:0]           div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quotient;

   assign req_stall = (state_ff != pwmtone_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign kind      = pwmtone_pkg::req_kind_type'(req_type);

   // elapsed times wrap modulo 2^32
   assign tone_elapsed  = time_now_ff - tone_begin_ff;
   assign slide_elapsed = time_now_ff - slide_mark_ff;
   assign tone_running  = (tone_elapsed[31:16] == 16'd0) && (tone_elapsed[15:0] < tone_length_ff);

   assign slide_sum = $signed({2'b00, cur_freq_ff}) + $signed({{10{cur_slide_ff[7]}}, cur_slide_ff});
   assign pos_next  = melody_pos_ff + 5'd1;
   assign pos_next9 = {4'd0, pos_next};
   assign index9    = {5'd0, req_entry_index};
   assign count9    = {4'd0, req_melody_count};
   assign duty_eff  = (cur_duty_ff > pwmtone_pkg::DUTY_MAX) ? pwmtone_pkg::DUTY_MAX : cur_duty_ff;
   assign product_in = pwmtone_pkg::PRODUCT_W'(duty_eff) * pwmtone_pkg::PRODUCT_W'(period_ff);
   // registered product times the reciprocal of 100
   assign scaled     = SCALED_W'(product_ff) * SCALED_W'(pwmtone_pkg::PERCENT_RECIP);

   // melody memory: written straight from the request, read ahead of s_load
   assign mem_wr_en         = accept && (kind == pwmtone_pkg::REQ_WRITE) && (index9 < DEPTH9);
   assign mem_wr_addr       = index9[AW-1:0];
   assign mem_wr_data.freq  = req_tone_frequency;
   assign mem_wr_data.duty  = req_tone_duty;
   assign mem_wr_data.slide = req_tone_slide;
   assign mem_wr_data.dur   = req_tone_duration;
   assign mem_rd_addr       = (state_ff == pwmtone_pkg::S_TICK) ? pos_next9[AW-1:0] : '0;

   pwmtone_store #(
      .DEPTH (MELODY_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // divider: timer clock / frequency, started only for a nonzero frequency
   assign div_start    = (state_ff == pwmtone_pkg::S_RELOAD) && (cur_freq_ff != 16'd0);
   assign div_dividend = HZ_VALUE;
   assign div_divisor  = cur_freq_ff;

   pwmtone_div #(
      .WIDTH (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer: next state and all next register values
   always_comb begin
      state_in       = state_ff;
      time_now_in    = time_now_ff;
      tone_begin_in  = tone_begin_ff;
      slide_mark_in  = slide_mark_ff;
      tone_length_in = tone_length_ff;
      cur_freq_in    = cur_freq_ff;
      cur_duty_in    = cur_duty_ff;
      cur_slide_in   = cur_slide_ff;
      period_in      = period_ff;
      pulse_in       = pulse_ff;
      melody_pos_in  = melody_pos_ff;
      melody_len_in  = melody_len_ff;
      melody_on_in   = melody_on_ff;
      paused_in      = paused_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_period_in  = rsp_period_ff;
      rsp_compare_in = rsp_compare_ff;
      rsp_sound_in   = rsp_sound_ff;
      rsp_tone_in    = rsp_tone_ff;
      rsp_melody_in  = rsp_melody_ff;

      case (state_ff)
         pwmtone_pkg::S_IDLE: begin
            if (accept) begin
               case (kind)
                  pwmtone_pkg::REQ_TICK: begin
                     time_now_in = time_now_ff + 32'd1;
                     state_in    = pwmtone_pkg::S_TICK;
                  end
                  pwmtone_pkg::REQ_TONE: begin
                     cur_freq_in    = req_tone_frequency;
                     cur_duty_in    = req_tone_duty;
                     cur_slide_in   = req_tone_slide;
                     tone_length_in = req_tone_duration;
                     tone_begin_in  = time_now_ff;
                     slide_mark_in  = time_now_ff;
                     if (!mute_ff) begin
                        paused_in = 1'b0;
                     end
                     state_in = pwmtone_pkg::S_FINISH;
                  end
                  pwmtone_pkg::REQ_WRITE: begin
                     state_in = pwmtone_pkg::S_FINISH;
                  end
                  pwmtone_pkg::REQ_MELODY: begin
                     if (req_melody_count == 5'd0) begin
                        state_in = pwmtone_pkg::S_FINISH;
                     end else begin
                        // count clamped to the store depth
                        melody_len_in = (count9 > DEPTH9) ? DEPTH9[4:0] : req_melody_count;
                        melody_pos_in = 5'd0;
                        melody_on_in  = 1'b1;
                        state_in      = pwmtone_pkg::S_LOAD;
                     end
                  end
                  default: begin
                     state_in = pwmtone_pkg::S_FINISH;
                  end
               endcase
            end
         end

         pwmtone_pkg::S_TICK: begin
            if (tone_running && !mute_ff) begin
               // slide every 5 ms, saturating to the 16-bit range
               if (slide_elapsed >= SLIDE_MS) begin
                  if (slide_sum < 18'sd0) begin
                     cur_freq_in = 16'd0;
                  end else if (slide_sum > $signed({2'b00, pwmtone_pkg::PERIOD_MAX})) begin
                     cur_freq_in = pwmtone_pkg::PERIOD_MAX;
                  end else begin
                     cur_freq_in = slide_sum[15:0];
                  end
                  slide_mark_in = time_now_ff;
               end
               state_in = pwmtone_pkg::S_RELOAD;
            end else if (melody_on_ff && !mute_ff) begin
               if ((pos_next < melody_len_ff) && (pos_next9 < DEPTH9)) begin
                  melody_pos_in = pos_next;
                  state_in      = pwmtone_pkg::S_LOAD;
               end else begin
                  melody_on_in = 1'b0;
                  state_in     = pwmtone_pkg::S_FINISH;
               end
            end else begin
               paused_in = 1'b1;
               state_in  = pwmtone_pkg::S_FINISH;
            end
         end

         pwmtone_pkg::S_LOAD: begin
            // entry read was issued in the previous cycle
            cur_freq_in    = mem_rd_data.freq;
            cur_duty_in    = mem_rd_data.duty;
            cur_slide_in   = mem_rd_data.slide;
            tone_length_in = mem_rd_data.dur;
            tone_begin_in  = time_now_ff;
            slide_mark_in  = time_now_ff;
            if (!mute_ff) begin
               paused_in = 1'b0;
            end
            state_in = pwmtone_pkg::S_FINISH;
         end

         pwmtone_pkg::S_RELOAD: begin
            // zero frequency is silence; otherwise the divider starts here
            if (cur_freq_ff == 16'd0) begin
               period_in = 16'd0;
               pulse_in  = 16'd0;
               state_in  = pwmtone_pkg::S_FINISH;
            end else begin
               state_in = pwmtone_pkg::S_DIV_PERIOD;
            end
         end

         pwmtone_pkg::S_DIV_PERIOD: begin
            if (div_done) begin
               period_in = (|div_quotient[DIV_W-1:16]) ? pwmtone_pkg::PERIOD_MAX
                                                        : div_quotient[15:0];
               state_in  = pwmtone_pkg::S_MUL;
            end
         end

         pwmtone_pkg::S_MUL: begin
            // duty * period lands in the product register
            state_in = pwmtone_pkg::S_SCALE;
         end

         pwmtone_pkg::S_SCALE: begin
            // divide by 100 through the reciprocal, exact over the product range
            pulse_in = scaled[pwmtone_pkg::RECIP_SHIFT +: 16];
            state_in = pwmtone_pkg::S_FINISH;
         end

         pwmtone_pkg::S_FINISH: begin
            // wait for the response register to free up
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_period_in  = (period_ff != 16'd0) ? (period_ff - 16'd1) : 16'd0;
               rsp_compare_in = (pulse_ff != 16'd0) ? (pulse_ff - 16'd1) : 16'd0;
               rsp_sound_in   = !paused_ff;
               rsp_tone_in    = tone_running;
               rsp_melody_in  = melody_on_ff;
               state_in       = pwmtone_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pwmtone_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwmtone_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff    <= '0;
         tone_begin_ff  <= '0;
         slide_mark_ff  <= '0;
         tone_length_ff <= '0;
         cur_freq_ff    <= '0;
         cur_duty_ff    <= '0;
         cur_slide_ff   <= '0;
         period_ff      <= '0;
         pulse_ff       <= '0;
         melody_pos_ff  <= '0;
         melody_len_ff  <= '0;
         melody_on_ff   <= 1'b0;
         paused_ff      <= 1'b1;
         mute_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         time_now_ff    <= time_now_in;
         tone_begin_ff  <= tone_begin_in;
         slide_mark_ff  <= slide_mark_in;
         tone_length_ff <= tone_length_in;
         cur_freq_ff    <= cur_freq_in;
         cur_duty_ff    <= cur_duty_in;
         cur_slide_ff   <= cur_slide_in;
         period_ff      <= period_in;
         pulse_ff       <= pulse_in;
         melody_pos_ff  <= melody_pos_in;
         melody_len_ff  <= melody_len_in;
         melody_on_ff   <= melody_on_in;
         paused_ff      <= paused_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            mute_ff <= csr_wr_data;
         end
      end
   end

   // duty * period, sampled every cycle and used in s_scale
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // response payload, held while stalled
   always_ff @(posedge clock) begin
      rsp_period_ff  <= rsp_period_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_sound_ff   <= rsp_sound_in;
      rsp_tone_ff    <= rsp_tone_in;
      rsp_melody_ff  <= rsp_melody_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_period_top    = rsp_period_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_sound_on      = rsp_sound_ff;
   assign rsp_tone_active   = rsp_tone_ff;
   assign rsp_melody_active = rsp_melody_ff;

   // between requests the pulse never exceeds the period it was scaled from
   a_pulse_within_period: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pwmtone_pkg::S_IDLE) |-> (pulse_ff <= period_ff))
      else $error("pulse above period");

   // a playing melody always points inside its length
   a_melody_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      melody_on_ff |-> (melody_pos_ff < melody_len_ff))
      else $error("melody position past length");

   // divider results only arrive while the sequencer waits for them
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pwmtone_pkg::S_DIV_PERIOD))
      else $error("divider done outside its wait state");

   // an accepted tick moves time forward by one
   a_tick_advances_time: assert property (@(posedge clock) disable iff (reset)
      (accept && kind == pwmtone_pkg::REQ_TICK) |=> (time_now_ff == $past(time_now_ff) + 32'd1))
      else $error("tick did not advance time");

endmodule
